// ----- rtl/knap_pkg.sv -----
package knap_pkg;

  localparam int unsigned WEIGHT_W = 10;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned CAP_W    = 10;
  localparam int unsigned BEST_W   = 32;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 10'd1023;

  // register word indexes on the APB port
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [WEIGHT_W-1:0] item_weight;
    logic [VALUE_W-1:0]  item_value;
    logic                last_item;
  } in_item_t;

  typedef struct packed {
    logic [BEST_W-1:0] best_value;
    logic              saturated;
  } out_item_t;

  // per-entry control for the update stage
  typedef struct packed {
    logic upd;        // an entry is in the update stage
    logic fit;        // weight fits at this capacity
    logic last;       // item closes the problem
    logic hit_cap;    // entry is the reported capacity
    logic start;      // new item accepted
    logic done_step;  // entry is the final one of the sweep
  } sweep_ctl_t;

endpackage

// ----- rtl/knap_ram.sv -----
module knap_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/knap_cfg.sv -----
module knap_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [knap_pkg::CAP_W-1:0] capacity
);

  logic [knap_pkg::CAP_W-1:0] capacity_r;
  logic [knap_pkg::CAP_W-1:0] capacity_nxt;
  logic                       wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == knap_pkg::REG_CAPACITY);

  always_comb begin
    capacity_nxt = capacity_r;
    if (wr_hit) begin
      capacity_nxt = pwdata[knap_pkg::CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= knap_pkg::CAPACITY_RESET;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == knap_pkg::REG_CAPACITY) begin
      prdata = {{(32 - knap_pkg::CAP_W){1'b0}}, capacity_r};
    end
  end

  assign capacity = capacity_r;

endmodule

// ----- rtl/knap_dp.sv -----
module knap_dp #(
  parameter int unsigned SUM_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  knap_pkg::sweep_ctl_t          ctl,
  input  logic [knap_pkg::VALUE_W-1:0]  item_value,
  input  logic [SUM_BITS-1:0]           old_val,
  input  logic [SUM_BITS-1:0]           low_val,
  output logic [SUM_BITS-1:0]           wdata,
  output logic                          out_valid,
  output knap_pkg::out_item_t           out_item
);

  localparam int unsigned ADD_W = ((SUM_BITS > knap_pkg::VALUE_W) ?
                                   SUM_BITS : knap_pkg::VALUE_W) + 1;
  localparam logic [ADD_W-1:0] TOP = ADD_W'({SUM_BITS{1'b1}});

  logic [ADD_W-1:0]    sum;
  logic                sum_ovf;
  logic [SUM_BITS-1:0] cand;
  logic [SUM_BITS-1:0] new_val;
  logic                ovf_hit;
  logic [SUM_BITS-1:0] report_val;

  logic                sat_r;
  logic                sat_nxt;
  logic [SUM_BITS-1:0] cap_val_r;
  logic [SUM_BITS-1:0] cap_val_nxt;
  logic                out_valid_r;
  knap_pkg::out_item_t out_item_r;

  always_comb begin
    sum     = ADD_W'(item_value) + ADD_W'(low_val);
    sum_ovf = (sum > TOP);
    cand    = sum_ovf ? {SUM_BITS{1'b1}} : sum[SUM_BITS-1:0];
    new_val = (ctl.fit && (cand > old_val)) ? cand : old_val;
    // the closing sweep zeroes the row behind it
    wdata   = ctl.last ? '0 : new_val;
    ovf_hit = ctl.upd && ctl.fit && sum_ovf;
  end

  always_comb begin
    cap_val_nxt = cap_val_r;
    if (ctl.start) begin
      cap_val_nxt = '0;
    end else if (ctl.upd && ctl.hit_cap) begin
      cap_val_nxt = new_val;
    end
    report_val = (ctl.upd && ctl.hit_cap) ? new_val : cap_val_r;

    sat_nxt = sat_r;
    if (ctl.upd && ctl.done_step && ctl.last) begin
      sat_nxt = 1'b0;
    end else if (ovf_hit) begin
      sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sat_r       <= sat_nxt;
      out_valid_r <= ctl.upd && ctl.done_step && ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    cap_val_r <= cap_val_nxt;
    if (ctl.upd && ctl.done_step) begin
      out_item_r.best_value <= 32'(report_val);
      out_item_r.saturated  <= sat_r || ovf_hit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- rtl/knapsack_01_max_value.sv -----
// Channel   | Ports                          | Transfer
// ----------+--------------------------------+---------------------------------------
// input     | start, busy, in_item           | start high while busy low
// result    | out_valid, out_item            | one-cycle strobe, cannot be stalled
// config    | psel, penable, pwrite, paddr,  | APB write at access phase, pready
//           | pwdata, prdata, pready         | tied high; capacity at address 0
//
// An item sweeps the best-value row from the top capacity down to 1, one
// entry per cycle through the dual-read row RAM; busy holds off the next item.
// The last item of a problem zeroes the row during its own sweep; its answer
// strobes on out_valid the cycle after the sweep ends.
// After reset the row is cleared entry by entry with busy high;
// configuration writes are taken meanwhile. The receiver cannot stall results.
module knapsack_01_max_value #(
  parameter int unsigned ROW_DEPTH = 1024,
  parameter int unsigned SUM_BITS  = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  knap_pkg::in_item_t  in_item,
  output logic                out_valid,
  output knap_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned IDX_W = $clog2(ROW_DEPTH);
  localparam int unsigned CMP_W = ((IDX_W > knap_pkg::CAP_W) ? IDX_W : knap_pkg::CAP_W) + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROW_DEPTH - 1);
  localparam logic [IDX_W-1:0] ONE_IDX  = IDX_W'(1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [IDX_W-1:0]           j_r, j_nxt;
  logic [IDX_W-1:0]           j1_r, j1_nxt;
  logic                       upd_r, upd_nxt;
  logic                       fit1_r, fit1_nxt;
  knap_pkg::in_item_t         item_r, item_nxt;

  logic [knap_pkg::CAP_W-1:0] capacity;
  logic [IDX_W-1:0]           cap_idx;
  logic [CMP_W-1:0]           j_ext;
  logic [CMP_W-1:0]           w_ext;
  logic [CMP_W-1:0]           j_minus_w;
  logic                       fit_issue;
  logic                       accept;

  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  logic [SUM_BITS-1:0]        ram_wdata;
  logic [SUM_BITS-1:0]        old_val;
  logic [SUM_BITS-1:0]        low_val;
  logic [SUM_BITS-1:0]        upd_wdata;
  knap_pkg::sweep_ctl_t       ctl;

  knap_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  // clamp the reported capacity to the row
  always_comb begin
    if (32'(capacity) > 32'(ROW_DEPTH - 1)) begin
      cap_idx = LAST_IDX;
    end else begin
      cap_idx = IDX_W'(capacity);
    end
  end

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    j_ext     = CMP_W'(j_r);
    w_ext     = CMP_W'(item_r.item_weight);
    j_minus_w = j_ext - w_ext;
    fit_issue = (j_ext >= w_ext);
  end

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    j1_nxt    = j_r;
    upd_nxt   = 1'b0;
    fit1_nxt  = fit_issue;
    item_nxt  = item_r;
    case (state_r)
      ST_CLEAR: begin
        j_nxt = j_r - ONE_IDX;
        if (j_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          j_nxt     = LAST_IDX;
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        upd_nxt = 1'b1;
        j_nxt   = j_r - ONE_IDX;
        if (j_r == ONE_IDX) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      j_r     <= LAST_IDX;
      upd_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      upd_r   <= upd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j1_r   <= j1_nxt;
    fit1_r <= fit1_nxt;
    item_r <= item_nxt;
  end

  // read the entry and its partner at capacity minus weight; partners lie
  // below the sweep front, so no write of this sweep can be pending on them
  knap_ram #(
    .WIDTH (SUM_BITS),
    .DEPTH (ROW_DEPTH)
  ) u_row (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (j_r),
    .rdata_a (old_val),
    .raddr_b (j_minus_w[IDX_W-1:0]),
    .rdata_b (low_val)
  );

  always_comb begin
    ctl.upd       = upd_r;
    ctl.fit       = fit1_r;
    ctl.last      = item_r.last_item;
    ctl.hit_cap   = (j1_r == cap_idx);
    ctl.start     = accept;
    ctl.done_step = (state_r == ST_DRAIN);
  end

  knap_dp #(
    .SUM_BITS (SUM_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .item_value (item_r.item_value),
    .old_val    (old_val),
    .low_val    (low_val),
    .wdata      (upd_wdata),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = j_r;
      ram_wdata = '0;
    end else begin
      ram_we    = upd_r;
      ram_waddr = j1_r;
      ram_wdata = upd_wdata;
    end
  end

endmodule

// ----- rtl/knap_checker.sv -----
module knap_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // an accepted transaction always occupies the block
  assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // answers come one at a time, never back to back
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // an answer ends a sweep: block was busy before and is free now
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of a sweep");

  // reset starts the row clearing pass
  assert property (@(posedge clk) !rst_n |=> busy)
    else $error("block not busy clearing after reset");

endmodule

bind knapsack_01_max_value knap_checker u_knap_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

// ----- test/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROW_DEPTH = 1024;
  localparam int unsigned SUM_BITS  = 32;
  localparam int unsigned CAP_W     = knap_pkg::CAP_W;
  localparam int unsigned WEIGHT_W  = knap_pkg::WEIGHT_W;
  localparam int unsigned VALUE_W   = knap_pkg::VALUE_W;
  localparam int unsigned BEST_W    = knap_pkg::BEST_W;
  localparam bit [SUM_BITS:0] SUM_TOP = {1'b0, {SUM_BITS{1'b1}}};
  // word index with no register behind it
  localparam logic REG_SPARE = ~knap_pkg::REG_CAPACITY;
  localparam int unsigned MAX_GAP = 18;

  logic                clk     = 1'b0;
  logic                rst_n   = 1'b0;
  logic                start   = 1'b0;
  logic                busy;
  knap_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  knap_pkg::out_item_t out_item;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [2:0]          paddr   = '0;
  logic [31:0]         pwdata  = '0;
  logic [31:0]         prdata;
  logic                pready;

  // predictor state
  bit [SUM_BITS-1:0]   best_row [ROW_DEPTH];
  bit                  sum_clamped;
  bit [CAP_W-1:0]      capacity_reg = knap_pkg::CAPACITY_RESET;
  knap_pkg::out_item_t answers_due [$];

  int unsigned mismatches = 0;
  bit          quiet_run  = 1'b0;

  knapsack_01_max_value #(
    .ROW_DEPTH(ROW_DEPTH),
    .SUM_BITS (SUM_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #30ms;
    $display("** knapsack_01_max_value: FAILED **");
    $finish;
  end

  // fold one item into the row of best values, answer on the last item
  task automatic pack_item(input knap_pkg::in_item_t it);
    bit [SUM_BITS:0]     cand;
    int unsigned         w;
    int unsigned         cap;
    knap_pkg::out_item_t ans;
    w = 32'(it.item_weight);
    for (int j = ROW_DEPTH - 1; j >= 1; j--) begin
      if (w <= j) begin
        cand = (SUM_BITS+1)'(it.item_value) + (SUM_BITS+1)'(best_row[j - w]);
        if (cand > SUM_TOP) begin
          cand = SUM_TOP;
          sum_clamped = 1'b1;
        end
        if (cand > best_row[j]) best_row[j] = cand[SUM_BITS-1:0];
      end
    end
    best_row[0] = '0;
    if (it.last_item) begin
      cap = 32'(capacity_reg);
      if (cap > ROW_DEPTH - 1) cap = ROW_DEPTH - 1;
      ans.best_value = best_row[cap][BEST_W-1:0];
      ans.saturated  = sum_clamped;
      answers_due.push_back(ans);
      foreach (best_row[j]) best_row[j] = '0;
      sum_clamped = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    knap_pkg::out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (answers_due.size() == 0) begin
        $display("%0t: expected no result, actual best_value %0d saturated %0b", $time,
                 out_item.best_value, out_item.saturated);
        mismatches++;
      end else begin
        want = answers_due.pop_front();
        if (out_item.best_value !== want.best_value) begin
          $display("%0t: best_value expected %0d actual %0d", $time,
                   want.best_value, out_item.best_value);
          mismatches++;
        end
        if (out_item.saturated !== want.saturated) begin
          $display("%0t: saturated expected %0b actual %0b", $time,
                   want.saturated, out_item.saturated);
          mismatches++;
        end
      end
    end
  end

  // send one transaction; sometimes hold until the sweep is over, then idle
  task automatic send_item(input knap_pkg::in_item_t it);
    int unsigned gap;
    bit          after_sweep;
    gap         = quiet_run ? 0 : $urandom_range(MAX_GAP, 0);
    after_sweep = !quiet_run && ($urandom_range(1, 0) == 1);
    if (gap > 0 || after_sweep) begin
      start <= 1'b0;
      if (after_sweep) begin
        do @(posedge clk); while (busy);
      end
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    pack_item(it);
  endtask

  task automatic send(input logic [WEIGHT_W-1:0] w, input logic [VALUE_W-1:0] v,
                      input logic last);
    knap_pkg::in_item_t it;
    it.item_weight = w;
    it.item_value  = v;
    it.last_item   = last;
    send_item(it);
  endtask

  // drain all answers and let a trailing sweep finish before touching registers
  task automatic settle();
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (ROW_DEPTH + 16) @(posedge clk);
  endtask

  task automatic cfg_access(input logic idx, input bit wr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == knap_pkg::REG_CAPACITY) begin
      if (wr) begin
        capacity_reg = data[CAP_W-1:0];
      end else if (prdata[CAP_W-1:0] !== capacity_reg) begin
        $display("%0t: capacity readback expected %0d actual %0d", $time,
                 capacity_reg, prdata[CAP_W-1:0]);
        mismatches++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    logic [31:0] data;
    data = $urandom;
    data[CAP_W-1:0] = cap;
    cfg_access(knap_pkg::REG_CAPACITY, 1'b1, data);
    cfg_access(knap_pkg::REG_CAPACITY, 1'b0, '0);
  endtask

  task automatic test_reset_capacity();
    // read while the row is still being cleared
    cfg_access(knap_pkg::REG_CAPACITY, 1'b0, '0);
    send(10'd1023, 16'hFFFF, 1'b1);
    send(10'd0, 16'd0, 1'b1);
  endtask

  task automatic test_zero_weight();
    send(10'd0, 16'd100, 1'b0);
    send(10'd0, 16'd200, 1'b0);
    send(10'd5, 16'hFFFF, 1'b1);
  endtask

  task automatic test_small_capacity();
    settle();
    set_capacity(10'd0);
    send(10'd0, 16'd5, 1'b1);
    settle();
    set_capacity(10'd1);
    send(10'd1, 16'd7, 1'b0);
    send(10'd1, 16'd9, 1'b1);
    send(10'd2, 16'd3, 1'b1);
  endtask

  task automatic test_textbook();
    settle();
    set_capacity(10'd7);
    send(10'd1, 16'd1, 1'b0);
    send(10'd3, 16'd4, 1'b0);
    send(10'd4, 16'd5, 1'b0);
    send(10'd5, 16'd7, 1'b1);
  endtask

  // the row holds across a register write between items of one problem
  task automatic test_capacity_mid_problem();
    settle();
    set_capacity(10'd1023);
    send(10'd3, 16'd10, 1'b0);
    settle();
    set_capacity(10'd3);
    send(10'd2, 16'd4, 1'b1);
  endtask

  task automatic test_unknown_register();
    settle();
    cfg_access(REG_SPARE, 1'b1, 32'hFFFF_FFFF);
    cfg_access(knap_pkg::REG_CAPACITY, 1'b0, '0);
    send(10'd1023, 16'hFFFF, 1'b0);
    send(10'd1, 16'd1, 1'b1);
  endtask

  task automatic test_random_problems(input int unsigned item_goal);
    int unsigned        sent;
    int unsigned        problems;
    int unsigned        n;
    int unsigned        wmax;
    knap_pkg::in_item_t it;
    sent     = 0;
    problems = 0;
    while (sent < item_goal) begin
      if (problems % 8 == 0) begin
        settle();
        case ($urandom_range(4, 0))
          0:       set_capacity(10'd0);
          1:       set_capacity(10'd1023);
          2:       set_capacity(10'd1);
          3:       set_capacity(CAP_W'($urandom_range(127, 0)));
          default: set_capacity(CAP_W'($urandom_range(1023, 0)));
        endcase
      end
      quiet_run = ($urandom_range(4, 0) == 0);
      n    = ($urandom_range(9, 0) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
      wmax = ($urandom_range(1, 0) == 1) ? 63 : 1023;
      for (int k = 0; k < n; k++) begin
        it.item_weight = WEIGHT_W'($urandom_range(wmax, 0));
        it.item_value  = ($urandom_range(1, 0) == 1) ? VALUE_W'($urandom_range(65535, 0))
                                                     : VALUE_W'($urandom_range(255, 0));
        it.last_item   = (k == n - 1);
        send_item(it);
        sent++;
      end
      problems++;
    end
    quiet_run = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_capacity();
    test_zero_weight();
    test_small_capacity();
    test_textbook();
    test_capacity_mid_problem();
    test_unknown_register();
    test_random_problems(563);
    settle();
    if (mismatches == 0) begin
      $display("** knapsack_01_max_value: PASSED **");
    end else begin
      $display("** knapsack_01_max_value: FAILED **");
    end
    $finish;
  end

endmodule
